// ----- src/amf3e_pkg.sv -----
// Shared types and constants of the AMF3 scalar value encoder.
package amf3e_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned MaxLen = 9;
  localparam int unsigned CntW   = 4;

  localparam logic [OpW-1:0] OP_UNDEF  = 3'd0;
  localparam logic [OpW-1:0] OP_NULL   = 3'd1;
  localparam logic [OpW-1:0] OP_BOOL   = 3'd2;
  localparam logic [OpW-1:0] OP_INT    = 3'd3;
  localparam logic [OpW-1:0] OP_DOUBLE = 3'd4;

  localparam logic [7:0] MK_UNDEF  = 8'h00;
  localparam logic [7:0] MK_NULL   = 8'h01;
  localparam logic [7:0] MK_FALSE  = 8'h02;
  localparam logic [7:0] MK_TRUE   = 8'h03;
  localparam logic [7:0] MK_INT    = 8'h04;
  localparam logic [7:0] MK_DOUBLE = 8'h05;

  // Double exponent of an integer normalized so its leading one sits at bit 31.
  localparam logic [10:0] EXP_BIAS31 = 11'd1054;

  // One encoded value: first byte in the lowest bits.
  typedef struct packed {
    logic [CntW-1:0]      count;
    logic [8*MaxLen-1:0]  bytes;
  } rec_t;

  // Classified value between the two front stages.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           flag;
    logic           fits;
    logic [28:0]    u29;
    logic [63:0]    dbits;
  } cls_t;

endpackage

// ----- src/amf3e_front.sv -----
// Front end: accept a value, classify it and build its byte record.
module amf3e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic               flag_value,
  input  logic signed [31:0] int_value,
  input  logic [63:0]        double_bits,
  output logic               push_valid,
  input  logic               push_ready,
  output amf3e_pkg::rec_t    push_rec
);

  // stage 1: input register
  logic               v1;
  logic [2:0]         op1;
  logic               flag1;
  logic [31:0]        ival1;
  logic [63:0]        dbits1;

  // stage 2: classified value
  logic               v2;
  amf3e_pkg::cls_t    cls2;
  amf3e_pkg::cls_t    cls_next;

  logic               s2_kind_ok;
  logic               s2_adv;
  logic               s2_ready;

  logic               sign1;
  logic [31:0]        mag1;
  logic [1:0]         lzc1;
  logic [31:0]        norm1;
  logic [63:0]        ibits1;

  assign s2_kind_ok = (cls2.op == amf3e_pkg::OP_UNDEF) || (cls2.op == amf3e_pkg::OP_NULL) ||
                      (cls2.op == amf3e_pkg::OP_BOOL) || (cls2.op == amf3e_pkg::OP_INT) ||
                      (cls2.op == amf3e_pkg::OP_DOUBLE);
  // drop unknown kinds without a push
  assign s2_adv   = v2 && (push_ready || !s2_kind_ok);
  assign s2_ready = !v2 || s2_adv;
  assign in_ready = !v1 || s2_ready;

  // An integer outside the U29 range has its leading one in bits 31..28.
  always_comb begin
    sign1 = ival1[31];
    mag1  = sign1 ? (~ival1 + 32'd1) : ival1;
    priority if (mag1[31]) lzc1 = 2'd0;
    else if (mag1[30])     lzc1 = 2'd1;
    else if (mag1[29])     lzc1 = 2'd2;
    else                   lzc1 = 2'd3;
    norm1  = mag1 << lzc1;
    ibits1 = {sign1, amf3e_pkg::EXP_BIAS31 - {9'd0, lzc1}, norm1[30:0], 21'd0};

    cls_next.op    = op1;
    cls_next.flag  = flag1;
    cls_next.fits  = sign1 ? (ival1[31:28] == 4'hF) : (ival1[31:28] == 4'h0);
    cls_next.u29   = ival1[28:0];
    cls_next.dbits = (op1 == amf3e_pkg::OP_INT) ? ibits1 : dbits1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (s2_ready) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op1    <= op;
      flag1  <= flag_value;
      ival1  <= int_value;
      dbits1 <= double_bits;
    end
    if (v1 && s2_ready) begin
      cls2 <= cls_next;
    end
  end

  // build the record
  logic [63:0] d;
  logic [28:0] u;
  always_comb begin
    d = cls2.dbits;
    u = cls2.u29;
    push_rec.bytes = '0;
    push_rec.count = 4'd1;
    unique case (cls2.op)
      amf3e_pkg::OP_UNDEF: push_rec.bytes[7:0] = amf3e_pkg::MK_UNDEF;
      amf3e_pkg::OP_NULL:  push_rec.bytes[7:0] = amf3e_pkg::MK_NULL;
      amf3e_pkg::OP_BOOL:
        push_rec.bytes[7:0] = cls2.flag ? amf3e_pkg::MK_TRUE : amf3e_pkg::MK_FALSE;
      amf3e_pkg::OP_INT: begin
        if (cls2.fits) begin
          priority if (u[28:7] == '0) begin
            push_rec.bytes[15:0] = {1'b0, u[6:0], amf3e_pkg::MK_INT};
            push_rec.count       = 4'd2;
          end else if (u[28:14] == '0) begin
            push_rec.bytes[23:0] = {1'b0, u[6:0], 1'b1, u[13:7], amf3e_pkg::MK_INT};
            push_rec.count       = 4'd3;
          end else if (u[28:21] == '0) begin
            push_rec.bytes[31:0] = {1'b0, u[6:0], 1'b1, u[13:7], 1'b1, u[20:14],
                                    amf3e_pkg::MK_INT};
            push_rec.count       = 4'd4;
          end else begin
            push_rec.bytes[39:0] = {u[7:0], 1'b1, u[14:8], 1'b1, u[21:15], 1'b1, u[28:22],
                                    amf3e_pkg::MK_INT};
            push_rec.count       = 4'd5;
          end
        end else begin
          push_rec.bytes = {d[7:0], d[15:8], d[23:16], d[31:24], d[39:32], d[47:40],
                            d[55:48], d[63:56], amf3e_pkg::MK_DOUBLE};
          push_rec.count = 4'd9;
        end
      end
      amf3e_pkg::OP_DOUBLE: begin
        push_rec.bytes = {d[7:0], d[15:8], d[23:16], d[31:24], d[39:32], d[47:40],
                          d[55:48], d[63:56], amf3e_pkg::MK_DOUBLE};
        push_rec.count = 4'd9;
      end
      default: push_rec.count = 4'd1;
    endcase
  end

  assign push_valid = v2 && s2_kind_ok;

endmodule

// ----- src/amf3e_queue.sv -----
// Two-entry record queue between front end and serializer.
module amf3e_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  amf3e_pkg::rec_t push_rec,
  output logic            pop_valid,
  input  logic            pop_en,
  output amf3e_pkg::rec_t pop_rec
);

  amf3e_pkg::rec_t entries [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      cnt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_rec    = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_rec;
    end
  end

endmodule

// ----- src/amf3e_back.sv -----
// Back end: serialize queued records one byte per unstalled cycle into the output register.
module amf3e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  output logic            rec_pop,
  input  amf3e_pkg::rec_t rec,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic                               busy;
  logic [8*(amf3e_pkg::MaxLen-1)-1:0] cur;
  logic [amf3e_pkg::CntW-1:0]         rem;
  logic                               load;

  assign load    = !out_valid || out_ready;
  assign rec_pop = load && !busy && rec_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      if (busy) begin
        out_valid <= 1'b1;
        busy      <= (rem != 4'd1);
      end else if (rec_valid) begin
        out_valid <= 1'b1;
        busy      <= (rec.count != 4'd1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (busy) begin
        out_byte <= cur[7:0];
        out_last <= (rem == 4'd1);
        cur      <= cur >> 8;
        rem      <= rem - 4'd1;
      end else if (rec_valid) begin
        // emit the marker now, hold the rest
        out_byte <= rec.bytes[7:0];
        out_last <= (rec.count == 4'd1);
        cur      <= rec.bytes[8*amf3e_pkg::MaxLen-1:8];
        rem      <= rec.count - 4'd1;
      end
    end
  end

endmodule

// ----- src/amf3_scalar_value_encoder.sv -----
// Top level of the AMF3 scalar value encoder.
//
// Input stream s_axis: one request per scalar value (undefined, null, boolean,
// integer or double bits). Output stream m_axis: the AMF3 encoding of each
// value, one byte per transfer, marker first, tlast on the value's final byte.
// Requests with an unknown kind (5..7) produce no bytes.
//
// Throughput: one output byte per cycle with no gap between values while the
// receiver takes every byte. Encodings are 1 byte for undefined, null and
// boolean, 2..5 for a U29 integer, 9 for a double or an out-of-range integer.
// The byte-wide output register sets this rate.
// When the serializer is free, the marker passes the input register, the
// classify register, the record queue and the output register in that order.
// A two-entry record queue lets new requests enter while the serializer still
// drains an earlier value; s_axis_tready drops once the queue and the front
// stages are full. When the receiver stalls, the output byte holds.
// Reset (rst, synchronous) empties every stage; no clearing pass is needed.
module amf3_scalar_value_encoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] op, [3] flag_value, [35:4] int_value, [99:36] double_bits, [103:100] zero
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast
);

  logic            push_valid;
  logic            push_ready;
  amf3e_pkg::rec_t push_rec;
  logic            pop_valid;
  logic            pop_en;
  amf3e_pkg::rec_t pop_rec;

  amf3e_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .op          (s_axis_tdata[2:0]),
    .flag_value  (s_axis_tdata[3]),
    .int_value   (s_axis_tdata[35:4]),
    .double_bits (s_axis_tdata[99:36]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_rec    (push_rec)
  );

  amf3e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_rec    (pop_rec)
  );

  amf3e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (pop_valid),
    .rec_pop   (pop_en),
    .rec       (pop_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- src/amf3e_checker.sv -----
// Port-level checker for the AMF3 scalar value encoder, bound to the top level.
module amf3e_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic         m_axis_tlast
);

  logic out_acc;
  logic first;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track whether the next output byte opens a new value
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (out_acc) begin
      first <= m_axis_tlast;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output byte changed");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_acc && first |-> m_axis_tdata <= amf3e_pkg::MK_DOUBLE)
    else $error("value does not open with a valid marker");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_acc && first && m_axis_tdata < amf3e_pkg::MK_INT |-> m_axis_tlast)
    else $error("single-byte marker not marked last");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(s_axis_tvalid && s_axis_tready) && !$past(s_axis_tvalid && s_axis_tready, 2) &&
    !$past(s_axis_tvalid && s_axis_tready, 3) && !$past(s_axis_tvalid && s_axis_tready, 4) &&
    !$past(m_axis_tvalid, 1) &&
    !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) |-> !m_axis_tvalid)
    else $error("output byte without a request");

endmodule

bind amf3_scalar_value_encoder amf3e_checker u_amf3e_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/amf3_scalar_value_encoder_tb.sv -----
// Self-checking testbench for the AMF3 scalar value encoder byte stream.
module amf3_scalar_value_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds outside the defined set; the block drops them without output.
  localparam logic [amf3e_pkg::OpW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [amf3e_pkg::OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [amf3e_pkg::OpW-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;

  enc_byte_t expected_bytes[$];
  enc_byte_t front_byte;
  int        mismatch_count = 0;
  bit        send_idle = 1'b1;
  bit        recv_idle = 1'b1;
  int        rx_hold_cycles = 0;

  amf3_scalar_value_encoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Exact binary64 bits of a 32-bit integer outside the U29 range (never zero).
  function automatic logic [63:0] int_as_double(input logic [31:0] raw);
    logic        sgn;
    logic [31:0] mag;
    logic [63:0] wide;
    int          msb;
    sgn = raw[31];
    mag = sgn ? (~raw + 32'd1) : raw;
    msb = 0;
    for (int i = 0; i < 32; i++)
      if (mag[i]) msb = i;
    wide = 64'(mag) << (52 - msb);
    return {sgn, 11'(1023 + msb), wide[51:0]};
  endfunction

  // Append the byte sequence one request should produce to expected_bytes.
  function automatic void predict_encoding(input logic [amf3e_pkg::OpW-1:0] op,
                                           input logic flg, input logic [31:0] ival,
                                           input logic [63:0] dbits);
    logic [7:0]  enc[$];
    logic [28:0] u;
    logic [63:0] bits;
    logic        fits;
    bits = dbits;
    case (op)
      amf3e_pkg::OP_UNDEF: enc.push_back(amf3e_pkg::MK_UNDEF);
      amf3e_pkg::OP_NULL:  enc.push_back(amf3e_pkg::MK_NULL);
      amf3e_pkg::OP_BOOL:  enc.push_back(flg ? amf3e_pkg::MK_TRUE : amf3e_pkg::MK_FALSE);
      amf3e_pkg::OP_INT: begin
        fits = ival[31] ? (ival >= 32'hF000_0000) : (ival <= 32'h0FFF_FFFF);
        if (fits) begin
          u = ival[28:0];
          enc.push_back(amf3e_pkg::MK_INT);
          if (u <= 29'h7F) begin
            enc.push_back({1'b0, u[6:0]});
          end else if (u <= 29'h3FFF) begin
            enc.push_back({1'b1, u[13:7]});
            enc.push_back({1'b0, u[6:0]});
          end else if (u <= 29'h1F_FFFF) begin
            enc.push_back({1'b1, u[20:14]});
            enc.push_back({1'b1, u[13:7]});
            enc.push_back({1'b0, u[6:0]});
          end else begin
            // Fourth byte carries a full 8 bits.
            enc.push_back({1'b1, u[28:22]});
            enc.push_back({1'b1, u[21:15]});
            enc.push_back({1'b1, u[14:8]});
            enc.push_back(u[7:0]);
          end
        end else begin
          bits = int_as_double(ival);
        end
      end
      default: ;
    endcase
    if (op == amf3e_pkg::OP_DOUBLE || (op == amf3e_pkg::OP_INT && enc.size() == 0)) begin
      enc.push_back(amf3e_pkg::MK_DOUBLE);
      for (int i = 7; i >= 0; i--)
        enc.push_back(bits[8*i +: 8]);
    end
    foreach (enc[i])
      expected_bytes.push_back('{data: enc[i], last: (i == enc.size() - 1)});
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_value(input logic [amf3e_pkg::OpW-1:0] op, input logic flg,
                            input logic [31:0] ival, input logic [63:0] dbits);
    @(negedge clk);
    while (send_idle && $urandom_range(99) < 37) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = {4'b0, dbits, ival, flg, op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_encoding(op, flg, ival, dbits);
  endtask

  // Stop offering and let every outstanding byte arrive.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] random_int();
    case ($urandom_range(5))
      0: return 32'($urandom_range(0, 32'h7F));
      1: return 32'($urandom_range(32'h80, 32'h3FFF));
      2: return 32'($urandom_range(32'h4000, 32'h1F_FFFF));
      3: return 32'($urandom_range(32'h20_0000, 32'h0FFF_FFFF));
      4: return 32'hF000_0000 | ($urandom & 32'h0FFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [amf3e_pkg::OpW-1:0] op;
    int r;
    r = $urandom_range(99);
    if (r < 5)       op = amf3e_pkg::OP_UNDEF;
    else if (r < 10) op = amf3e_pkg::OP_NULL;
    else if (r < 20) op = amf3e_pkg::OP_BOOL;
    else if (r < 60) op = amf3e_pkg::OP_INT;
    else if (r < 95) op = amf3e_pkg::OP_DOUBLE;
    else             op = 3'(amf3e_pkg::OP_DOUBLE + $urandom_range(1, 3));
    send_value(op, 1'($urandom), random_int(), {$urandom, $urandom});
  endtask

  task automatic test_directed();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    send_value(amf3e_pkg::OP_UNDEF, 1'b1, 32'hFFFF_FFFF, '1);
    send_value(amf3e_pkg::OP_NULL, 1'b0, 32'h0, junk);
    send_value(amf3e_pkg::OP_BOOL, 1'b0, 32'hFFFF_FFFF, '1);
    send_value(amf3e_pkg::OP_BOOL, 1'b1, 32'h0, '0);
    send_value(OP_SPARE5, 1'b1, $urandom, junk);
    send_value(OP_SPARE6, 1'b0, $urandom, '1);
    send_value(OP_SPARE7, 1'b1, 32'hFFFF_FFFF, '0);
    // U29 size boundaries, both ends of the range and just past them.
    send_value(amf3e_pkg::OP_INT, 1'b1, 32'd0, '1);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'd127, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'd128, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h3FFF, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h4000, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h1F_FFFF, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h20_0000, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h0FFF_FFFF, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h1000_0000, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'hFFFF_FFFF, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'hF000_0000, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'hEFFF_FFFF, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h8000_0000, junk);
    send_value(amf3e_pkg::OP_INT, 1'b0, 32'h7FFF_FFFF, junk);
    send_value(amf3e_pkg::OP_DOUBLE, 1'b1, 32'hFFFF_FFFF, '0);
    send_value(amf3e_pkg::OP_DOUBLE, 1'b0, 32'h0, '1);
    send_value(amf3e_pkg::OP_DOUBLE, 1'b1, $urandom, 64'h0123_4567_89AB_CDEF);
    wait_drained();
  endtask

  task automatic test_random_stream();
    repeat (110) send_random();
    wait_drained();
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (25) send_random();
    wait_drained();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Hold the output off long enough that the record queue fills and tready drops.
  task automatic test_output_stall();
    rx_hold_cycles = 80;
    repeat (12) send_value(amf3e_pkg::OP_DOUBLE, 1'($urandom), $urandom,
                           {$urandom, $urandom});
    repeat (6) send_random();
    wait_drained();
  endtask

  // Receiver: random stalls, plus a counted hold when a test requests one.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_cycles--;
      end else if (recv_idle && $urandom_range(99) < 37) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        front_byte = expected_bytes.pop_front();
        if (m_axis_tdata !== front_byte.data || m_axis_tlast !== front_byte.last) begin
          $display("%0t: byte mismatch: expected %02h last %0b, actual %02h last %0b",
                   $time, front_byte.data, front_byte.last, m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_stream();
    test_back_to_back();
    test_output_stall();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_bytes.size() != 0)
        $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/amf3e_pkg.sv
src/amf3e_front.sv
src/amf3e_queue.sv
src/amf3e_back.sv
src/amf3_scalar_value_encoder.sv
src/amf3e_checker.sv
bench/amf3_scalar_value_encoder_tb.sv
